// ===== sv/mcbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcbp_pkg: shared definitions for the motor command byte parser
// Command codes, reply characters and the reply record held in the output queue.
// ----------------------------------------------------------------------------
package mcbp_pkg;

  // command codes seen in idle
  localparam logic [7:0] CmdWidth    = 8'd1;
  localparam logic [7:0] CmdDir      = 8'd2;
  // direction byte value that selects reverse
  localparam logic [7:0] DirReverse  = 8'd1;

  // width masks for the two command bytes
  localparam logic [15:0] HighMask   = 16'hFF00;
  localparam logic [15:0] LowMask    = 16'h00FF;

  // reply characters
  localparam logic [7:0] ReplyAck    = 8'h30;  // '0'
  localparam logic [7:0] ReplyStart  = 8'h61;  // 'a'
  localparam logic [7:0] ReplyHigh   = 8'h62;  // 'b'
  localparam logic [7:0] ReplyWidth  = 8'h63;  // 'c'
  localparam logic [7:0] ReplyFwd    = 8'h65;  // 'e'
  localparam logic [7:0] ReplyRev    = 8'h66;  // 'f'

  // output queue depth
  localparam int unsigned QueueDepth = 2;

  // everything the replies of one byte need
  typedef struct packed {
    logic [7:0]  second_char;
    logic        has_second;
    logic [15:0] drive_width;
    logic        width_loaded;
    logic        reverse;
    logic        direction_loaded;
  } reply_rec_t;

endpackage

// ===== sv/motor_command_byte_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_command_byte_parser: serial command decoder for motor drive settings
// Decodes drive-width and direction commands from a byte stream and answers
// every byte with one or two reply characters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: rx_byte_i with in_valid_i / in_stall_o. A byte is taken at
//   a rising edge with in_valid_i high and in_stall_o low.
//   Output channel: reply_byte_o, reply_last_o and the status fields with
//   out_valid_o / out_stall_i. Each byte gives the reply '0', then for an
//   accepted command step a second reply; reply_last_o marks the final one.
//   The first reply of a byte is shown the cycle after it is taken, when no
//   earlier replies are pending. Throughput: one byte per cycle for bytes with
//   a single reply while out_stall_i is low; a byte with two replies uses the
//   output port, which moves one reply per cycle when not stalled, for both.
//   Decoding is done in the accepting cycle; the replies wait in a two-entry
//   queue, so a new byte is taken while earlier replies are still pending.
//   When the receiver stalls, the shown reply holds and the queue fills;
//   in_stall_o rises once both entries are occupied.
//   Reset: idle mode, drive width zero, direction forward, queue empty.
// ----------------------------------------------------------------------------
module motor_command_byte_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  // reply output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  reply_byte_o,
  output logic        reply_last_o,
  output logic [15:0] drive_width_o,
  output logic        width_loaded_o,
  output logic        reverse_o,
  output logic        direction_loaded_o
);

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_WIDTH = 2'd1,
    MODE_DIR   = 2'd2
  } mode_e;

  localparam int unsigned PtrW = $clog2(mcbp_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(mcbp_pkg::QueueDepth + 1);

  mode_e       mode_q, mode_d;
  logic [1:0]  idx_q, idx_d;
  logic [15:0] staged_q, staged_d;
  logic [15:0] applied_q, applied_d;
  logic        rev_q, rev_d;

  logic        in_acc;
  logic        out_pop;
  mcbp_pkg::reply_rec_t new_rec;
  mcbp_pkg::reply_rec_t head_rec;

  mcbp_pkg::reply_rec_t slot_q [mcbp_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, count_d;
  logic            phase_q;

  // handshakes
  assign in_stall_o  = (count_q == CntW'(mcbp_pkg::QueueDepth));
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (count_q != '0);
  assign out_pop     = out_valid_o && !out_stall_i && reply_last_o;

  // command decode for one byte
  always_comb begin
    mode_d    = mode_q;
    idx_d     = idx_q;
    staged_d  = staged_q;
    applied_d = applied_q;
    rev_d     = rev_q;
    new_rec.second_char      = mcbp_pkg::ReplyAck;
    new_rec.has_second       = 1'b0;
    new_rec.width_loaded     = 1'b0;
    new_rec.direction_loaded = 1'b0;
    unique case (mode_q)
      MODE_WIDTH: begin
        if (idx_q == 2'd1) begin
          staged_d = {rx_byte_i, 8'h00} & mcbp_pkg::HighMask;
          idx_d    = 2'd2;
          new_rec.second_char = mcbp_pkg::ReplyHigh;
        end else begin
          staged_d  = staged_q | ({8'h00, rx_byte_i} & mcbp_pkg::LowMask);
          applied_d = staged_d;
          mode_d    = MODE_IDLE;
          idx_d     = 2'd0;
          new_rec.width_loaded = 1'b1;
          new_rec.second_char  = mcbp_pkg::ReplyWidth;
        end
        new_rec.has_second = 1'b1;
      end
      MODE_DIR: begin
        if (rx_byte_i == mcbp_pkg::DirReverse) begin
          rev_d = 1'b1;
          new_rec.second_char = mcbp_pkg::ReplyRev;
        end else begin
          rev_d = 1'b0;
          new_rec.second_char = mcbp_pkg::ReplyFwd;
        end
        mode_d = MODE_IDLE;
        idx_d  = 2'd0;
        new_rec.direction_loaded = 1'b1;
        new_rec.has_second       = 1'b1;
      end
      default: begin
        // idle, and the unused mode code treated as idle
        mode_d = MODE_IDLE;
        if (rx_byte_i == mcbp_pkg::CmdWidth || rx_byte_i == mcbp_pkg::CmdDir) begin
          mode_d = (rx_byte_i == mcbp_pkg::CmdWidth) ? MODE_WIDTH : MODE_DIR;
          idx_d  = idx_q + 2'd1;
          new_rec.second_char = mcbp_pkg::ReplyStart;
          new_rec.has_second  = 1'b1;
        end
      end
    endcase
    new_rec.drive_width = applied_d;
    new_rec.reverse     = rev_d;
  end

  // command state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      idx_q     <= 2'd0;
      staged_q  <= '0;
      applied_q <= '0;
      rev_q     <= 1'b0;
    end else if (in_acc) begin
      mode_q    <= mode_d;
      idx_q     <= idx_d;
      staged_q  <= staged_d;
      applied_q <= applied_d;
      rev_q     <= rev_d;
    end
  end

  // reply queue occupancy
  always_comb begin
    count_d = count_q;
    if (in_acc && !out_pop) begin
      count_d = count_q + CntW'(1);
    end else if (!in_acc && out_pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      phase_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_acc) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (out_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
        phase_q  <= 1'b0;
      end else if (out_valid_o && !out_stall_i) begin
        phase_q <= 1'b1;
      end
    end
  end

  // reply records
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      slot_q[wr_ptr_q] <= new_rec;
    end
  end

  // reply output
  assign head_rec           = slot_q[rd_ptr_q];
  assign reply_byte_o       = phase_q ? head_rec.second_char : mcbp_pkg::ReplyAck;
  assign reply_last_o       = phase_q || !head_rec.has_second;
  assign drive_width_o      = head_rec.drive_width;
  assign width_loaded_o     = head_rec.width_loaded;
  assign reverse_o          = head_rec.reverse;
  assign direction_loaded_o = head_rec.direction_loaded;

endmodule

// ===== bench/mcbp_reply_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcbp_reply_checker: reply predictor and scoreboard for the byte parser
// Watches both channels of the motor command byte parser. Each accepted byte
// runs through a local copy of the command decoder, which queues the one or
// two replies it should cause. Each accepted reply is compared with the oldest
// queued one. The failure count and the number of replies still owed go to
// the bench top.
// ----------------------------------------------------------------------------
module mcbp_reply_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  reply_byte_i,
  input  logic        reply_last_i,
  input  logic [15:0] drive_width_i,
  input  logic        width_loaded_i,
  input  logic        reverse_i,
  input  logic        direction_loaded_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef enum logic [1:0] {
    ModeIdle  = 2'd0,
    ModeWidth = 2'd1,
    ModeDir   = 2'd2,
    ModeSpare = 2'd3
  } parse_mode_e;

  typedef struct packed {
    logic [7:0]  reply;
    logic        last;
    logic [15:0] width;
    logic        width_loaded;
    logic        reverse;
    logic        dir_loaded;
  } reply_t;

  // decoder copy
  parse_mode_e mode_q;
  logic [1:0]  index_q;
  logic [15:0] staged_q;
  logic [15:0] applied_q;
  logic        reverse_q;

  reply_t owed_replies[$];

  // decode one byte and queue the replies it should cause
  task automatic decode_byte(input logic [7:0] b);
    logic       has_second;
    logic [7:0] second;
    logic       wl;
    logic       dl;
    has_second = 1'b0;
    second     = 8'h00;
    wl         = 1'b0;
    dl         = 1'b0;
    case (mode_q)
      ModeWidth: begin
        if (index_q == 2'd1) begin
          staged_q = ({8'h00, b} << 8) & mcbp_pkg::HighMask;
          index_q  = 2'd2;
          second   = mcbp_pkg::ReplyHigh;
        end else begin
          staged_q  = staged_q | ({8'h00, b} & mcbp_pkg::LowMask);
          applied_q = staged_q;
          mode_q    = ModeIdle;
          index_q   = 2'd0;
          wl        = 1'b1;
          second    = mcbp_pkg::ReplyWidth;
        end
        has_second = 1'b1;
      end
      ModeDir: begin
        if (b == mcbp_pkg::DirReverse) begin
          reverse_q = 1'b1;
          second    = mcbp_pkg::ReplyRev;
        end else begin
          reverse_q = 1'b0;
          second    = mcbp_pkg::ReplyFwd;
        end
        mode_q     = ModeIdle;
        index_q    = 2'd0;
        dl         = 1'b1;
        has_second = 1'b1;
      end
      default: begin
        // idle, and the spare code treated as idle
        mode_q = ModeIdle;
        if (b == mcbp_pkg::CmdWidth || b == mcbp_pkg::CmdDir) begin
          mode_q     = (b == mcbp_pkg::CmdWidth) ? ModeWidth : ModeDir;
          index_q    = index_q + 2'd1;
          second     = mcbp_pkg::ReplyStart;
          has_second = 1'b1;
        end
      end
    endcase
    owed_replies.push_back('{mcbp_pkg::ReplyAck, !has_second, applied_q, wl,
                             reverse_q, dl});
    if (has_second) begin
      owed_replies.push_back('{second, 1'b1, applied_q, wl, reverse_q, dl});
    end
  endtask

  // compare replies, then decode the byte taken at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    reply_t seen;
    reply_t want;
    if (!rst_ni) begin
      mode_q    = ModeIdle;
      index_q   = 2'd0;
      staged_q  = 16'h0000;
      applied_q = 16'h0000;
      reverse_q = 1'b0;
      owed_replies.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        seen = '{reply_byte_i, reply_last_i, drive_width_i, width_loaded_i,
                 reverse_i, direction_loaded_i};
        if (owed_replies.size() == 0) begin
          $display("%0t: unexpected reply: char %h last %b width %h wl %b rev %b dl %b",
                   $time, seen.reply, seen.last, seen.width, seen.width_loaded,
                   seen.reverse, seen.dir_loaded);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = owed_replies.pop_front();
          if (seen !== want) begin
            $display("%0t: reply mismatch: expected char %h last %b width %h wl %b rev %b dl %b",
                     $time, want.reply, want.last, want.width, want.width_loaded,
                     want.reverse, want.dir_loaded);
            $display("%0t:                 actual   char %h last %b width %h wl %b rev %b dl %b",
                     $time, seen.reply, seen.last, seen.width, seen.width_loaded,
                     seen.reverse, seen.dir_loaded);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        decode_byte(rx_byte_i);
      end
      pending_o <= owed_replies.size();
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: bench for the motor command byte parser
// Sends a directed set of command bytes and then random width and direction
// commands mixed with stray bytes, about 1200 bytes in all, in bursts with
// random gaps, while the reply side stalls on its own pattern and once holds
// off long enough to fill the parser. A checker beside the parser scores
// replies.
// ----------------------------------------------------------------------------
module tb_top;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  reply_byte_o;
  logic        reply_last_o;
  logic [15:0] drive_width_o;
  logic        width_loaded_o;
  logic        reverse_o;
  logic        direction_loaded_o;

  int fail_count;
  int replies_owed;
  int burst_left = 0;
  int bytes_sent = 0;

  motor_command_byte_parser dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .reply_byte_o      (reply_byte_o),
    .reply_last_o      (reply_last_o),
    .drive_width_o     (drive_width_o),
    .width_loaded_o    (width_loaded_o),
    .reverse_o         (reverse_o),
    .direction_loaded_o(direction_loaded_o)
  );

  mcbp_reply_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .reply_byte_i      (reply_byte_o),
    .reply_last_i      (reply_last_o),
    .drive_width_i     (drive_width_o),
    .width_loaded_i    (width_loaded_o),
    .reverse_i         (reverse_o),
    .direction_loaded_i(direction_loaded_o),
    .fail_count_o      (fail_count),
    .pending_o         (replies_owed)
  );

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // reset
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // offer one byte, wait for it to be taken, then maybe pause between bursts
  task automatic offer_byte(input logic [7:0] b);
    int gap;
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 8);
    end
  endtask

  task automatic send_width(input logic [7:0] hi, input logic [7:0] lo);
    offer_byte(mcbp_pkg::CmdWidth);
    offer_byte(hi);
    offer_byte(lo);
  endtask

  task automatic send_direction(input logic [7:0] d);
    offer_byte(mcbp_pkg::CmdDir);
    offer_byte(d);
  endtask

  // request stimulus and verdict
  initial begin
    int pick;
    wait (rst_ni);
    @(posedge clk_i);

    // directed: stray bytes, width extremes, command codes as data, directions
    offer_byte(8'h00);
    offer_byte(8'hFF);
    offer_byte(8'h03);
    send_width(8'h00, 8'h00);
    send_width(8'hFF, 8'hFF);
    send_width(mcbp_pkg::CmdWidth, mcbp_pkg::CmdDir);
    send_direction(mcbp_pkg::DirReverse);
    send_direction(8'h00);
    send_direction(mcbp_pkg::DirReverse);
    send_direction(8'hFF);
    send_direction(mcbp_pkg::CmdDir);
    send_width(8'h55, 8'hAA);
    offer_byte(8'h80);

    // random: mostly well-formed commands with random content, some noise
    while (bytes_sent < 1200) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        send_width(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else if (pick < 7) begin
        send_direction(($urandom_range(0, 1) == 0) ? mcbp_pkg::DirReverse
                                                   : 8'($urandom_range(0, 255)));
      end else begin
        offer_byte(8'($urandom_range(0, 255)));
      end
    end
    in_valid_i <= 1'b0;

    // drain, then let any stray replies show
    @(posedge clk_i);
    while (replies_owed != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[motor_command_byte_parser] OK");
    end else begin
      $display("[motor_command_byte_parser] ERROR");
    end
    $finish;
  end

  // reply side stall pattern, with one long hold-off to fill the parser
  initial begin
    int cycle;
    cycle = 0;
    forever begin
      @(posedge clk_i);
      cycle++;
      if (cycle >= 1500 && cycle < 1800) begin
        out_stall_i <= 1'b1;
      end else begin
        case ((cycle >> 8) % 4)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= cycle[0];
        endcase
      end
    end
  end

  // run limit
  initial begin
    #5ms;
    $display("[motor_command_byte_parser] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/mcbp_pkg.sv
sv/motor_command_byte_parser.sv
bench/mcbp_reply_checker.sv
bench/tb_top.sv
